>>> rtl/core/discriminator_frame_decoder_defines.svh
// Assertion macros used by the frame decoder.
`ifndef DISCRIMINATOR_FRAME_DECODER_DEFINES_SVH
`define DISCRIMINATOR_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define DFD_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("frame decoder check failed");

`define DFD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("frame decoder check failed");

`else

`define DFD_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons)

`define DFD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

>>> rtl/core/dfd_pkg.sv
`timescale 1ns / 1ps

package dfd_pkg;

    localparam int POS_W   = 12;
    localparam int WORD_W  = 5;
    localparam int COUNT_W = 5;

    localparam logic [POS_W-1:0] POS_MAX      = 12'd4095;
    localparam logic [POS_W-1:0] HEADER_LAST  = 12'd11;
    localparam logic [POS_W-1:0] COUNTS01_POS = 12'd12;
    localparam logic [POS_W-1:0] COUNTS23_POS = 12'd13;
    localparam logic [POS_W-1:0] DATA_START   = 12'd14;

    localparam logic [WORD_W-1:0] ROWS_PER_HIT      = 5'd16;
    localparam logic [WORD_W-1:0] WORD_QUARTER_LOW  = 5'd16;
    localparam logic [WORD_W-1:0] WORD_QUARTER_HIGH = 5'd17;
    localparam logic [WORD_W-1:0] WORD_STAMP_LOW    = 5'd18;
    localparam logic [WORD_W-1:0] WORD_STAMP_HIGH   = 5'd19;

    localparam logic [1:0] STATUS_HIT      = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [1:0] STATUS_DUMMY    = 2'd2;

    typedef logic [3:0][3:0] hit_counts_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  trip_index;
        logic [3:0]  hit_index;
        logic [3:0]  channel_index;
        logic [1:0]  quarter_ticks;
        logic [4:0]  delay_ticks;
        logic [31:0] time_stamp;
        logic        burst_last;
    } out_item_t;

    typedef struct packed {
        logic clear_all;
        logic clear_count;
        logic add_row;
        logic load_qlo;
        logic load_qhi;
        logic load_snap;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> rtl/core/dfd_stream_if.sv
`timescale 1ns / 1ps

interface dfd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/dfd_cell.sv
`timescale 1ns / 1ps

module dfd_cell #(
    parameter int SRL_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfd_pkg::cell_ctrl_t ctrl,
    input  logic              row_bit,
    input  logic [1:0]        next_qt,
    input  logic [4:0]        next_dt,
    output logic [1:0]        snap_qt,
    output logic [4:0]        snap_dt
);
    import dfd_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic               qlo_reg;
    logic               qhi_reg;
    logic [1:0]         snap_qt_reg;
    logic [4:0]         snap_dt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            qlo_reg   <= 1'b0;
            qhi_reg   <= 1'b0;
        end
        else if (ctrl.clear_all)
        begin
            count_reg <= '0;
            qlo_reg   <= 1'b0;
            qhi_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_count)
            begin
                count_reg <= '0;
            end
            else if (ctrl.add_row)
            begin
                count_reg <= count_reg + COUNT_W'(row_bit);
            end
            if (ctrl.load_qlo)
            begin
                qlo_reg <= row_bit;
            end
            if (ctrl.load_qhi)
            begin
                qhi_reg <= row_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_snap)
        begin
            snap_qt_reg <= {qhi_reg, qlo_reg};
            snap_dt_reg <= 5'(SRL_DEPTH) - count_reg;
        end
        else if (ctrl.shift)
        begin
            snap_qt_reg <= next_qt;
            snap_dt_reg <= next_dt;
        end
    end

    assign snap_qt = snap_qt_reg;
    assign snap_dt = snap_dt_reg;

endmodule

>>> rtl/core/discriminator_frame_decoder.sv
// Discriminator frame decoder: one frame byte per transaction, one byte per cycle unless stalled.
// An error result appears in the cycle after header byte 11 is taken.
// A hit's CHANNELS results start the cycle after its last byte, one per cycle while ready.
// Input stalls only when header byte 11 or a hit's last byte meets an undrained burst.
// Reset (rst_n, asynchronous, active low) returns the parser to frame start.
`timescale 1ns / 1ps

`include "discriminator_frame_decoder_defines.svh"

module discriminator_frame_decoder #(
    parameter int CHANNELS     = 16,
    parameter int SRL_DEPTH    = 16,
    parameter int LEN_HIGH_POS = 0,
    parameter int LEN_LOW_POS  = 1,
    parameter int DUMMY_POS    = 11
) (
    input logic          clk,
    input logic          rst_n,
    dfd_stream_if.sink   frame_in,
    dfd_stream_if.source result_out
);
    import dfd_pkg::*;

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam logic [CNT_W-1:0] CH_COUNT = CNT_W'(CHANNELS);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              len_nz_reg, len_nz_next;
    logic              failed_reg, failed_next;
    hit_counts_t       hits_reg, hits_next;
    logic [1:0]        trip_reg, trip_next;
    logic [3:0]        hit_reg, hit_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [7:0]        hold_reg, hold_next;
    logic [15:0]       stamp_lo_reg, stamp_lo_next;

    logic [CNT_W-1:0]  burst_count_reg;
    logic [1:0]        burst_status_reg;
    logic [1:0]        burst_trip_reg;
    logic [3:0]        burst_hit_reg;
    logic [31:0]       burst_ts_reg;

    logic [7:0]  in_byte;
    logic        in_end;
    logic        in_fire;
    logic        out_fire;
    logic [15:0] data_word;
    logic        in_header;
    logic        header_last;
    logic        ln_new;
    logic        ff_new;
    logic        err_zero;
    logic        err_dummy;
    logic        active;
    logic        word_done;
    logic        hit_done;
    logic        may_emit;
    logic        load_hit;
    logic        load_err;
    logic        is_hit;
    logic [3:0]  hit_inc;
    hit_counts_t hits_cleared;

    cell_ctrl_t  ctrl;
    logic [1:0]  chain_qt [CHANNELS+1];
    logic [4:0]  chain_dt [CHANNELS+1];

    function automatic logic [1:0] pick_trip(input hit_counts_t counts, input logic [1:0] current);
        logic [1:0] sel;
        sel = current;
        for (int t = 3; t >= 0; t--)
        begin
            if (counts[t] != 4'd0)
            begin
                sel = 2'(t);
            end
        end
        return sel;
    endfunction

    assign in_byte   = frame_in.data.frame_byte;
    assign in_end    = frame_in.data.frame_end;
    assign in_fire   = frame_in.valid && frame_in.ready;
    assign out_fire  = result_out.valid && result_out.ready;
    assign data_word = {in_byte, hold_reg};

    assign in_header   = pos_reg <= HEADER_LAST;
    assign header_last = pos_reg == HEADER_LAST;
    assign ln_new      = len_nz_reg || (in_byte != 8'd0 &&
                         (pos_reg == POS_W'(LEN_HIGH_POS) || pos_reg == POS_W'(LEN_LOW_POS)));
    assign ff_new      = failed_reg || (in_byte != 8'd0 && pos_reg == POS_W'(DUMMY_POS));
    assign err_zero    = header_last && !ln_new;
    assign err_dummy   = header_last && ln_new && ff_new;

    assign active    = !in_header && !failed_reg && pos_reg >= DATA_START &&
                       hits_reg[trip_reg] != 4'd0;
    assign word_done = active && pos_reg[0];
    assign hit_done  = word_done && word_reg == WORD_STAMP_HIGH;
    assign may_emit  = header_last || hit_done;

    assign frame_in.ready = (burst_count_reg == '0) || !may_emit;

    assign load_hit = in_fire && hit_done;
    assign load_err = in_fire && (err_zero || err_dummy);

    assign hit_inc = hit_reg + 4'd1;

    always_comb
    begin
        hits_cleared           = hits_reg;
        hits_cleared[trip_reg] = 4'd0;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        len_nz_next   = len_nz_reg;
        failed_next   = failed_reg;
        hits_next     = hits_reg;
        trip_next     = trip_reg;
        hit_next      = hit_reg;
        word_next     = word_reg;
        hold_next     = hold_reg;
        stamp_lo_next = stamp_lo_reg;
        if (in_fire)
        begin
            if (in_header)
            begin
                len_nz_next = ln_new;
                failed_next = ff_new || err_zero;
            end
            else if (!failed_reg)
            begin
                if (pos_reg == COUNTS01_POS)
                begin
                    hits_next[0] = in_byte[3:0];
                    hits_next[1] = in_byte[7:4];
                end
                else if (pos_reg == COUNTS23_POS)
                begin
                    hits_next[2] = in_byte[3:0];
                    hits_next[3] = in_byte[7:4];
                    hit_next     = 4'd0;
                    word_next    = '0;
                    trip_next    = pick_trip({in_byte[7:4], in_byte[3:0],
                                              hits_reg[1], hits_reg[0]}, trip_reg);
                end
                else if (active)
                begin
                    if (!pos_reg[0])
                    begin
                        hold_next = in_byte;
                    end
                    else
                    begin
                        if (word_reg == WORD_STAMP_LOW)
                        begin
                            stamp_lo_next = data_word;
                        end
                        if (word_reg == WORD_STAMP_HIGH)
                        begin
                            if (hit_inc >= hits_reg[trip_reg])
                            begin
                                hits_next = hits_cleared;
                                hit_next  = 4'd0;
                                trip_next = pick_trip(hits_cleared, trip_reg);
                            end
                            else
                            begin
                                hit_next = hit_inc;
                            end
                            word_next = '0;
                        end
                        else
                        begin
                            word_next = word_reg + 5'd1;
                        end
                    end
                end
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 12'd1;
            end
            if (in_end)
            begin
                pos_next      = '0;
                len_nz_next   = 1'b0;
                failed_next   = 1'b0;
                hits_next     = '0;
                trip_next     = 2'd0;
                hit_next      = 4'd0;
                word_next     = '0;
                hold_next     = 8'd0;
                stamp_lo_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            len_nz_reg   <= 1'b0;
            failed_reg   <= 1'b0;
            hits_reg     <= '0;
            trip_reg     <= 2'd0;
            hit_reg      <= 4'd0;
            word_reg     <= '0;
            hold_reg     <= 8'd0;
            stamp_lo_reg <= 16'd0;
        end
        else
        begin
            pos_reg      <= pos_next;
            len_nz_reg   <= len_nz_next;
            failed_reg   <= failed_next;
            hits_reg     <= hits_next;
            trip_reg     <= trip_next;
            hit_reg      <= hit_next;
            word_reg     <= word_next;
            hold_reg     <= hold_next;
            stamp_lo_reg <= stamp_lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_count_reg  <= '0;
            burst_status_reg <= STATUS_HIT;
        end
        else if (load_hit)
        begin
            burst_count_reg  <= CH_COUNT;
            burst_status_reg <= STATUS_HIT;
        end
        else if (load_err)
        begin
            burst_count_reg  <= CNT_W'(1);
            burst_status_reg <= err_zero ? STATUS_ZERO_LEN : STATUS_DUMMY;
        end
        else if (out_fire)
        begin
            burst_count_reg <= burst_count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            burst_trip_reg <= trip_reg;
            burst_hit_reg  <= hit_reg;
            burst_ts_reg   <= {data_word, stamp_lo_reg};
        end
        else if (load_err)
        begin
            burst_trip_reg <= 2'd0;
            burst_hit_reg  <= 4'd0;
            burst_ts_reg   <= 32'd0;
        end
    end

    always_comb
    begin
        ctrl.clear_all   = in_fire && in_end;
        ctrl.clear_count = in_fire && hit_done;
        ctrl.add_row     = in_fire && word_done && word_reg < ROWS_PER_HIT &&
                           word_reg < 5'(SRL_DEPTH);
        ctrl.load_qlo    = in_fire && word_done && word_reg == WORD_QUARTER_LOW;
        ctrl.load_qhi    = in_fire && word_done && word_reg == WORD_QUARTER_HIGH;
        ctrl.load_snap   = load_hit;
        ctrl.shift       = out_fire;
    end

    assign chain_qt[CHANNELS] = 2'd0;
    assign chain_dt[CHANNELS] = 5'd0;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        dfd_cell #(
            .SRL_DEPTH (SRL_DEPTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .row_bit (data_word[i]),
            .next_qt (chain_qt[i+1]),
            .next_dt (chain_dt[i+1]),
            .snap_qt (chain_qt[i]),
            .snap_dt (chain_dt[i])
        );
    end

    assign is_hit = burst_status_reg == STATUS_HIT;

    assign result_out.valid              = burst_count_reg != '0;
    assign result_out.data.status        = burst_status_reg;
    assign result_out.data.trip_index    = burst_trip_reg;
    assign result_out.data.hit_index     = burst_hit_reg;
    assign result_out.data.channel_index = is_hit ? 4'(CH_COUNT - burst_count_reg) : 4'd0;
    assign result_out.data.quarter_ticks = is_hit ? chain_qt[0] : 2'd0;
    assign result_out.data.delay_ticks   = is_hit ? chain_dt[0] : 5'd0;
    assign result_out.data.time_stamp    = burst_ts_reg;
    assign result_out.data.burst_last    = burst_count_reg == CNT_W'(1);

    `DFD_ASSERT_NOW(a_load_only_when_empty, clk, rst_n, load_hit || load_err, burst_count_reg == '0)
    `DFD_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, burst_count_reg <= CH_COUNT)
    `DFD_ASSERT_NOW(a_error_single, clk, rst_n, result_out.valid && !is_hit,
                    burst_count_reg == CNT_W'(1))
    `DFD_ASSERT_NEXT(a_last_drains, clk, rst_n, out_fire && burst_count_reg == CNT_W'(1),
                     burst_count_reg == '0)

endmodule

>>> tb/sv/dfd_result_checker.sv
`timescale 1ns / 1ps

module dfd_result_checker #(
    parameter int CHANNELS     = 16,
    parameter int SRL_DEPTH    = 16,
    parameter int LEN_HIGH_POS = 0,
    parameter int LEN_LOW_POS  = 1,
    parameter int DUMMY_POS    = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  dfd_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  dfd_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 expected_left
);
    import dfd_pkg::*;

    localparam logic [WORD_W-1:0] WORDS_PER_HIT = 5'd20;

    logic [POS_W-1:0]   byte_pos;
    logic               length_seen;
    logic               frame_bad;
    logic [3:0]         trip_hits [4];
    logic [1:0]         trip_sel;
    logic [3:0]         hit_num;
    logic [WORD_W-1:0]  word_num;
    logic [7:0]         low_hold;
    logic [COUNT_W-1:0] column_ones [16];
    logic [15:0]        quarter_lo;
    logic [15:0]        quarter_hi;
    logic [15:0]        stamp_lo;
    out_item_t          expected_results [$];

    task automatic restart_frame();
        byte_pos    = '0;
        length_seen = 1'b0;
        frame_bad   = 1'b0;
        trip_sel    = '0;
        hit_num     = '0;
        word_num    = '0;
        low_hold    = '0;
        quarter_lo  = '0;
        quarter_hi  = '0;
        stamp_lo    = '0;
        for (int t = 0; t < 4; t++)
        begin
            trip_hits[t] = '0;
        end
        for (int ch = 0; ch < 16; ch++)
        begin
            column_ones[ch] = '0;
        end
    endtask

    // The lowest trip with hits left is served next; the selection stays put when none is left.
    task automatic select_trip();
        bit found;
        found = 1'b0;
        for (int t = 0; t < 4; t++)
        begin
            if (!found && trip_hits[t] != 4'd0)
            begin
                trip_sel = 2'(t);
                found    = 1'b1;
            end
        end
    endtask

    task automatic push_error(input logic [1:0] code);
        out_item_t r;
        r            = '0;
        r.status     = code;
        r.burst_last = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic decode_frame_byte(input logic [7:0] b, input logic last);
        logic [15:0] w;
        out_item_t   r;
        int          ch;
        if (byte_pos <= HEADER_LAST)
        begin
            if (byte_pos == LEN_HIGH_POS && b != 8'd0)
            begin
                length_seen = 1'b1;
            end
            if (byte_pos == LEN_LOW_POS && b != 8'd0)
            begin
                length_seen = 1'b1;
            end
            if (byte_pos == DUMMY_POS && b != 8'd0)
            begin
                frame_bad = 1'b1;
            end
            if (byte_pos == HEADER_LAST)
            begin
                if (!length_seen)
                begin
                    push_error(STATUS_ZERO_LEN);
                    frame_bad = 1'b1;
                end
                else if (frame_bad)
                begin
                    push_error(STATUS_DUMMY);
                end
            end
        end
        else if (!frame_bad)
        begin
            if (byte_pos == COUNTS01_POS)
            begin
                trip_hits[0] = b[3:0];
                trip_hits[1] = b[7:4];
            end
            else if (byte_pos == COUNTS23_POS)
            begin
                trip_hits[2] = b[3:0];
                trip_hits[3] = b[7:4];
                hit_num      = '0;
                word_num     = '0;
                select_trip();
            end
            else if (byte_pos >= DATA_START && trip_hits[trip_sel] != 4'd0)
            begin
                if (!byte_pos[0])
                begin
                    low_hold = b;
                end
                else
                begin
                    w = {b, low_hold};
                    if (word_num < ROWS_PER_HIT)
                    begin
                        if (word_num < SRL_DEPTH)
                        begin
                            for (ch = 0; ch < CHANNELS; ch++)
                            begin
                                column_ones[ch] = column_ones[ch] + COUNT_W'(w[ch]);
                            end
                        end
                    end
                    else if (word_num == WORD_QUARTER_LOW)
                    begin
                        quarter_lo = w;
                    end
                    else if (word_num == WORD_QUARTER_HIGH)
                    begin
                        quarter_hi = w;
                    end
                    else if (word_num == WORD_STAMP_LOW)
                    begin
                        stamp_lo = w;
                    end
                    else
                    begin
                        for (ch = 0; ch < CHANNELS; ch++)
                        begin
                            r               = '0;
                            r.status        = STATUS_HIT;
                            r.trip_index    = trip_sel;
                            r.hit_index     = hit_num;
                            r.channel_index = 4'(ch);
                            r.quarter_ticks = {quarter_hi[ch], quarter_lo[ch]};
                            r.delay_ticks   = COUNT_W'(SRL_DEPTH) - column_ones[ch];
                            r.time_stamp    = {w, stamp_lo};
                            r.burst_last    = (ch == CHANNELS - 1);
                            expected_results.push_back(r);
                        end
                        for (ch = 0; ch < 16; ch++)
                        begin
                            column_ones[ch] = '0;
                        end
                        hit_num = hit_num + 4'd1;
                        if (hit_num >= trip_hits[trip_sel])
                        begin
                            trip_hits[trip_sel] = '0;
                            hit_num             = '0;
                            select_trip();
                        end
                    end
                    word_num = (word_num + 5'd1 >= WORDS_PER_HIT) ? '0 : word_num + 5'd1;
                end
            end
        end
        if (byte_pos < POS_MAX)
        begin
            byte_pos = byte_pos + 1'b1;
        end
        if (last)
        begin
            restart_frame();
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result transaction with none expected, actual %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            report_field("status", want.status, got.status);
            report_field("trip_index", want.trip_index, got.trip_index);
            report_field("hit_index", want.hit_index, got.hit_index);
            report_field("channel_index", want.channel_index, got.channel_index);
            report_field("quarter_ticks", want.quarter_ticks, got.quarter_ticks);
            report_field("delay_ticks", want.delay_ticks, got.delay_ticks);
            report_field("time_stamp", want.time_stamp, got.time_stamp);
            report_field("burst_last", want.burst_last, got.burst_last);
        end
    endtask

    // A result leaving at an edge always stems from an earlier frame byte, so it is checked first.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restart_frame();
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
            end
            if (in_valid && in_ready)
            begin
                decode_frame_byte(in_data.frame_byte, in_data.frame_end);
            end
        end
        expected_left = expected_results.size();
    end

endmodule

>>> tb/sv/discriminator_frame_decoder_tb.sv
`timescale 1ns / 1ps

module discriminator_frame_decoder_tb;
    import dfd_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_IDLE         = 13;
    localparam int DRAIN_CYCLES     = 24;
    localparam int RANDOM_BYTES     = 40;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   expected_left;
    bit   sender_idles;
    bit   receiver_stalls;
    logic [7:0] frame_bytes [$];

    dfd_stream_if #(.T(in_item_t))  frame_if ();
    dfd_stream_if #(.T(out_item_t)) result_if ();

    discriminator_frame_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_if),
        .result_out (result_if)
    );

    dfd_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (frame_if.valid),
        .in_ready      (frame_if.ready),
        .in_data       (frame_if.data),
        .out_valid     (result_if.valid),
        .out_ready     (result_if.ready),
        .out_data      (result_if.data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("discriminator_frame_decoder_tb failed");
            $finish;
        end
    end

    initial
    begin : result_drain
        int stall;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= '{frame_byte: b, frame_end: last};
        do @(posedge clk); while (!frame_if.ready);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    task automatic wait_drained();
        frame_if.valid <= 1'b0;
        do @(negedge clk); while (expected_left != 0);
        @(posedge clk);
    endtask

    task automatic add_noise(input int count);
        for (int i = 0; i < count; i++)
        begin
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic add_word(input logic [15:0] w);
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(w[15:8]);
    endtask

    // Bytes 2 to 10 of the header carry nothing that the decoder looks at.
    task automatic add_header(input logic [15:0] len, input logic [7:0] dummy);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        add_noise(9);
        frame_bytes.push_back(dummy);
    endtask

    task automatic add_counts(input logic [3:0] c0, input logic [3:0] c1,
                              input logic [3:0] c2, input logic [3:0] c3);
        frame_bytes.push_back({c1, c0});
        frame_bytes.push_back({c3, c2});
    endtask

    task automatic add_hit(input logic [15:0] and_mask, input logic [15:0] or_mask,
                           input logic [15:0] qlo, input logic [15:0] qhi,
                           input logic [31:0] stamp);
        for (int row = 0; row < 16; row++)
        begin
            add_word((16'($urandom) & and_mask) | or_mask);
        end
        add_word(qlo);
        add_word(qhi);
        add_word(stamp[15:0]);
        add_word(stamp[31:16]);
    endtask

    function automatic logic [3:0] small_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return 4'd0;
        end
        else if (r < 9)
        begin
            return 4'd1;
        end
        return 4'($urandom_range(2, 3));
    endfunction

    initial
    begin
        int         kind;
        int         total;
        int         full;
        int         rand_bytes;
        bit         paused_once;
        logic [3:0] trip_count [4];

        rand_bytes      = 0;
        paused_once     = 1'b0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        rst_n          <= 1'b0;
        frame_if.valid <= 1'b0;
        frame_if.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_header(16'h0000, 8'h00);
        add_noise(5);
        send_frame();

        add_header(16'h0000, 8'hFF);
        send_frame();

        add_header(16'h0100, 8'h80);
        add_counts(4'd1, 4'd1, 4'd1, 4'd1);
        add_noise(6);
        send_frame();

        add_noise(6);
        send_frame();

        add_header(16'hFFFF, 8'h00);
        send_frame();

        add_header(16'h0001, 8'h00);
        add_counts(4'd0, 4'd1, 4'd0, 4'd1);
        add_hit(16'h0000, 16'hFFFF, 16'h5555, 16'h3333, 32'hFFFF_FFFF);
        add_hit(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        add_noise(7);
        send_frame();

        add_header(16'h0040, 8'h00);
        add_counts(4'd0, 4'd0, 4'd0, 4'd0);
        add_noise(4);
        send_frame();

        add_header(16'h0200, 8'h00);
        add_counts(4'd2, 4'd0, 4'd0, 4'd0);
        add_hit(16'hFFFF, 16'h0000, 16'hAAAA, 16'hCCCC, 32'h8000_0001);
        add_noise(9);
        send_frame();

        wait_drained();

        while (rand_bytes < RANDOM_BYTES)
        begin
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                total = 0;
                for (int t = 0; t < 4; t++)
                begin
                    trip_count[t] = small_count();
                    total += trip_count[t];
                end
                add_header(16'($urandom_range(1, 65535)), 8'h00);
                add_counts(trip_count[0], trip_count[1], trip_count[2], trip_count[3]);
                full = total;
                if (total != 0 && $urandom_range(0, 3) == 0)
                begin
                    full = $urandom_range(0, total - 1);
                end
                for (int h = 0; h < full; h++)
                begin
                    add_hit(16'($urandom), 16'($urandom) & 16'($urandom) & 16'($urandom),
                            16'($urandom), 16'($urandom), $urandom);
                end
                if (full < total)
                begin
                    add_noise($urandom_range(1, 39));
                end
                else
                begin
                    add_noise($urandom_range(0, 5));
                end
            end
            else if (kind == 7)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    add_header(16'h0000, 8'($urandom));
                end
                else
                begin
                    add_header(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)));
                end
                add_noise($urandom_range(0, 10));
            end
            else if (kind == 8)
            begin
                add_noise($urandom_range(1, 11));
            end
            else
            begin
                add_header(16'($urandom), ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom));
                add_noise($urandom_range(0, 60));
            end
            rand_bytes += frame_bytes.size();
            send_frame();
            if (!paused_once && rand_bytes > RANDOM_BYTES / 2)
            begin
                paused_once = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("discriminator_frame_decoder_tb passed");
        end
        else
        begin
            $display("discriminator_frame_decoder_tb failed");
        end
        $finish;
    end

endmodule
